// ----- rtl/ifsb_pkg.sv -----
package ifsb_pkg;

    localparam int ANGLE_W   = 16;
    localparam int SPEED_W   = 24;
    localparam int CUR_W     = 16;
    localparam int PHASE_W   = 2;
    localparam int SANG_W    = 27;
    localparam int SSPD_W    = 40;
    localparam int THR_W     = 23;
    localparam int PER_W     = 16;
    localparam int CFG_W     = 23;
    localparam int CFG_IDX_W = 2;
    localparam int K_W       = 17;
    localparam int ACC_W     = 32;
    localparam int DIV_STEPS = 16;
    localparam int MOD_STEPS = 5;
    localparam int CNT_W     = 4;

    localparam logic [CFG_IDX_W-1:0] REG_STARTUP_CURRENT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_SPEED     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_END_SPEED       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_PERIOD     = 2'd3;

    localparam logic [PHASE_W-1:0] PH_OPEN   = 2'd0;
    localparam logic [PHASE_W-1:0] PH_TRANS  = 2'd1;
    localparam logic [PHASE_W-1:0] PH_CLOSED = 2'd2;

    localparam logic [SANG_W-1:0] TWO_PI_Q24      = 27'd105414357;
    localparam logic [4:0]        RAMP_RATE       = 5'd20;
    localparam logic [K_W-1:0]    K_ONE           = 17'h10000;
    localparam logic [PER_W-1:0]  STEP_PERIOD_RST = 16'd839;

    // 2*pi scaled by 2^j, for the wrap reduction
    function automatic logic [ACC_W-1:0] two_pi_shl(input logic [2:0] j);
        return {{(ACC_W-SANG_W){1'b0}}, TWO_PI_Q24} << j;
    endfunction

    typedef struct packed {
        logic             load;
        logic             mul;
        logic             integ;
        logic             iter;
        logic [CNT_W-1:0] idx;
        logic             blend_mul;
        logic             blend_sum;
        logic             commit;
    } ifsb_cmd_t;

    typedef struct packed {
        logic out_full;
    } ifsb_stat_t;

endpackage

// ----- rtl/ifsb_ctrl.sv -----
module ifsb_ctrl
    import ifsb_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       m_ready,
    input  ifsb_stat_t stat,
    output ifsb_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_INTEG,
        ST_ITER,
        ST_BMUL,
        ST_BSUM,
        ST_FIN
    } state_t;

    state_t           state_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign out_free = !stat.out_full || m_ready;

    always_comb begin
        cmd           = '0;
        cmd.load      = s_valid && (state_reg == ST_IDLE);
        cmd.mul       = (state_reg == ST_MUL);
        cmd.integ     = (state_reg == ST_INTEG);
        cmd.iter      = (state_reg == ST_ITER);
        cmd.idx       = cnt_reg;
        cmd.blend_mul = (state_reg == ST_BMUL);
        cmd.blend_sum = (state_reg == ST_BSUM);
        cmd.commit    = (state_reg == ST_FIN) && out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) state_reg <= ST_MUL;
                end
                ST_MUL: begin
                    state_reg <= ST_INTEG;
                end
                ST_INTEG: begin
                    cnt_reg   <= '0;
                    state_reg <= ST_ITER;
                end
                ST_ITER: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(DIV_STEPS - 1)) state_reg <= ST_BMUL;
                end
                ST_BMUL: begin
                    state_reg <= ST_BSUM;
                end
                ST_BSUM: begin
                    state_reg <= ST_FIN;
                end
                ST_FIN: begin
                    if (out_free) state_reg <= ST_IDLE;
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- rtl/ifsb_dp.sv -----
module ifsb_dp
    import ifsb_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_W-1:0]            cfg_wdata,
    input  logic                        s_kind,
    input  logic signed [SPEED_W-1:0]   s_observer_speed,
    input  logic signed [ANGLE_W-1:0]   s_observer_angle,
    input  logic                        m_ready,
    input  ifsb_cmd_t                   cmd,
    output ifsb_stat_t                  stat,
    output logic                        m_valid,
    output logic signed [ANGLE_W-1:0]   m_angle_out,
    output logic signed [SPEED_W-1:0]   m_speed_out,
    output logic signed [CUR_W-1:0]     m_current_ref,
    output logic [PHASE_W-1:0]          m_phase_out
);

    typedef enum logic [1:0] {K_ZERO, K_FULL, K_DIV} kmode_t;

    // configuration
    logic signed [CUR_W-1:0] cur_cfg_reg;
    logic [THR_W-1:0]        start_reg;
    logic [THR_W-1:0]        end_reg;
    logic [PER_W-1:0]        period_reg;

    // persistent state
    logic [PHASE_W-1:0]      phase_reg;
    logic [SANG_W-1:0]       sang_reg;
    logic [SSPD_W-1:0]       sspd_reg;

    // per-word working registers
    logic                        kind_reg;
    logic signed [SPEED_W-1:0]   obs_w_reg;
    logic signed [ANGLE_W-1:0]   obs_a_reg;
    logic                        active_reg;
    kmode_t                      kmode_reg;
    logic signed [CUR_W-1:0]     cur_reg;
    logic [SSPD_W+PER_W-1:0]     prod_reg;
    logic                        wrap_reg;
    logic [ACC_W-1:0]            modx_reg;
    logic [THR_W-1:0]            rem_reg;
    logic [THR_W-1:0]            ad_reg;
    logic [DIV_STEPS-1:0]        q_reg;
    logic                        kone_reg;
    logic [K_W+SANG_W-1:0]       pa1_reg;
    logic signed [K_W+ANGLE_W:0] pa2_reg;
    logic [K_W+SSPD_W-1:0]       ps1_reg;
    logic signed [K_W+SPEED_W:0] ps2_reg;
    logic signed [ANGLE_W+1:0]   ang_full_reg;
    logic signed [SPEED_W+1:0]   spd_full_reg;
    logic                        out_full_reg;

    // combinational
    logic [SSPD_W-1:0]           start24;
    logic [SSPD_W-1:0]           end24;
    logic signed [SPEED_W:0]     num;
    logic signed [SPEED_W-1:0]   den;
    logic [SPEED_W:0]            an;
    logic [SPEED_W-1:0]          ad;
    kmode_t                      kmode_next;
    logic [ACC_W-1:0]            inc;
    logic [ACC_W-1:0]            sum;
    logic [20:0]                 ramp_inc;
    logic [SSPD_W-1:0]           spd_add;
    logic [SSPD_W-1:0]           sspd_next;
    logic [THR_W:0]              rem2;
    logic                        qbit;
    logic [ACC_W-1:0]            mod_m;
    logic [SANG_W-1:0]           sang_next;
    logic [K_W-1:0]              k_val;
    logic [K_W-1:0]              kc;
    logic signed [ANGLE_W+29:0]  va;
    logic signed [SPEED_W+33:0]  vs;
    logic [PHASE_W-1:0]          phase_next;
    logic signed [ANGLE_W-1:0]   ang_clamp;
    logic signed [SPEED_W-1:0]   spd_clamp;

    assign start24 = {1'b0, start_reg, 16'b0};
    assign end24   = {1'b0, end_reg, 16'b0};

    assign num = {obs_w_reg[SPEED_W-1], obs_w_reg} - $signed({2'b00, start_reg});
    assign den = $signed({1'b0, end_reg}) - $signed({1'b0, start_reg});
    assign an  = num[SPEED_W] ? (SPEED_W+1)'(-num) : num;
    assign ad  = den[SPEED_W-1] ? SPEED_W'(-den) : den;

    always_comb begin
        if (den == '0)
            kmode_next = K_FULL;
        else if (num == '0 || (num[SPEED_W] != den[SPEED_W-1]))
            kmode_next = K_ZERO;
        else if (an >= {1'b0, ad})
            kmode_next = K_FULL;
        else
            kmode_next = K_DIV;
    end

    // angle step, rounded half up to Q.24
    assign inc = ACC_W'((prod_reg + (SSPD_W+PER_W)'(1 << 23)) >> 24);
    assign sum = {{(ACC_W-SANG_W){1'b0}}, sang_reg} + inc;

    assign ramp_inc = 21'(RAMP_RATE) * 21'(period_reg);
    assign spd_add  = sspd_reg + SSPD_W'(ramp_inc);

    always_comb begin
        sspd_next = sspd_reg;
        if (phase_reg == PH_OPEN) begin
            sspd_next = (spd_add > start24) ? start24 : spd_add;
        end else if (phase_reg == PH_TRANS && sspd_reg < end24) begin
            sspd_next = (spd_add > end24) ? end24 : spd_add;
        end
    end

    // one restoring division step
    assign rem2 = {rem_reg, 1'b0};
    assign qbit = (rem2 >= {1'b0, ad_reg});

    assign mod_m = two_pi_shl(3'(MOD_STEPS - 1) - cmd.idx[2:0]);

    always_comb begin
        if (!active_reg)
            sang_next = sang_reg;
        else if (wrap_reg)
            sang_next = SANG_W'(modx_reg + 1'b1);
        else
            sang_next = SANG_W'(modx_reg);
    end

    always_comb begin
        case (kmode_reg)
            K_FULL:  k_val = K_ONE;
            K_DIV:   k_val = {1'b0, q_reg};
            default: k_val = '0;
        endcase
    end
    assign kc = K_ONE - k_val;

    assign va = $signed({2'b00, pa1_reg}) + $signed({pa2_reg, 12'b0})
              + $signed((ANGLE_W+30)'(1 << 27));
    assign vs = $signed({1'b0, ps1_reg}) + $signed({ps2_reg, 16'b0})
              + $signed((SPEED_W+34)'(1) <<< 31);

    always_comb begin
        phase_next = phase_reg;
        if (!kind_reg) begin
            if (phase_reg == PH_OPEN && sspd_reg >= start24)
                phase_next = PH_TRANS;
            else if (phase_reg == PH_TRANS && kone_reg)
                phase_next = PH_CLOSED;
        end
    end

    always_comb begin
        if (ang_full_reg > $signed((ANGLE_W+2)'(32767)))
            ang_clamp = 16'sh7FFF;
        else if (ang_full_reg < -$signed((ANGLE_W+2)'(32768)))
            ang_clamp = 16'sh8000;
        else
            ang_clamp = ang_full_reg[ANGLE_W-1:0];

        if (spd_full_reg > $signed((SPEED_W+2)'(8388607)))
            spd_clamp = 24'sh7FFFFF;
        else if (spd_full_reg < -$signed((SPEED_W+2)'(8388608)))
            spd_clamp = 24'sh800000;
        else
            spd_clamp = spd_full_reg[SPEED_W-1:0];
    end

    assign stat.out_full = out_full_reg;
    assign m_valid       = out_full_reg;

    // configuration and persistent state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_cfg_reg <= '0;
            start_reg   <= '0;
            end_reg     <= '0;
            period_reg  <= STEP_PERIOD_RST;
            phase_reg   <= PH_OPEN;
            sang_reg    <= '0;
            sspd_reg    <= '0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_STARTUP_CURRENT: cur_cfg_reg <= cfg_wdata[CUR_W-1:0];
                    REG_START_SPEED:     start_reg   <= cfg_wdata[THR_W-1:0];
                    REG_END_SPEED:       end_reg     <= cfg_wdata[THR_W-1:0];
                    REG_STEP_PERIOD:     period_reg  <= cfg_wdata[PER_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.mul && kind_reg) begin
                phase_reg <= PH_OPEN;
                sang_reg  <= '0;
                sspd_reg  <= '0;
            end
            if (cmd.integ && active_reg) sspd_reg <= sspd_next;
            if (cmd.blend_mul) sang_reg <= sang_next;
            if (cmd.commit) phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_full_reg <= 1'b0;
        end else if (cmd.commit) begin
            out_full_reg <= 1'b1;
        end else if (m_ready) begin
            out_full_reg <= 1'b0;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg  <= s_kind;
            obs_w_reg <= s_observer_speed;
            obs_a_reg <= s_observer_angle;
        end
        if (cmd.mul) begin
            prod_reg <= sspd_reg * {{(SSPD_W-PER_W){1'b0}}, period_reg};
            rem_reg  <= an[THR_W-1:0];
            ad_reg   <= ad[THR_W-1:0];
            if (kind_reg) begin
                active_reg <= 1'b0;
                kmode_reg  <= K_ZERO;
                cur_reg    <= '0;
            end else if (phase_reg == PH_OPEN) begin
                active_reg <= 1'b1;
                kmode_reg  <= K_ZERO;
                cur_reg    <= cur_cfg_reg;
            end else if (phase_reg == PH_TRANS) begin
                active_reg <= 1'b1;
                kmode_reg  <= kmode_next;
                cur_reg    <= cur_cfg_reg;
            end else begin
                active_reg <= 1'b0;
                kmode_reg  <= K_FULL;
                cur_reg    <= '0;
            end
        end
        if (cmd.integ) begin
            wrap_reg <= (sum > {{(ACC_W-SANG_W){1'b0}}, TWO_PI_Q24});
            modx_reg <= (sum > {{(ACC_W-SANG_W){1'b0}}, TWO_PI_Q24}) ? sum - 1'b1 : sum;
        end
        if (cmd.iter) begin
            rem_reg <= qbit ? THR_W'(rem2 - {1'b0, ad_reg}) : rem2[THR_W-1:0];
            q_reg   <= {q_reg[DIV_STEPS-2:0], qbit};
            if (cmd.idx < CNT_W'(MOD_STEPS) && wrap_reg && modx_reg >= mod_m)
                modx_reg <= modx_reg - mod_m;
        end
        if (cmd.blend_mul) begin
            kone_reg <= (k_val == K_ONE);
            pa1_reg  <= kc * sang_next;
            pa2_reg  <= $signed({1'b0, k_val}) * obs_a_reg;
            ps1_reg  <= kc * sspd_reg;
            ps2_reg  <= $signed({1'b0, k_val}) * obs_w_reg;
        end
        if (cmd.blend_sum) begin
            ang_full_reg <= va[ANGLE_W+29:28];
            spd_full_reg <= vs[SPEED_W+33:32];
        end
        if (cmd.commit) begin
            m_angle_out   <= ang_clamp;
            m_speed_out   <= spd_clamp;
            m_current_ref <= cur_reg;
            m_phase_out   <= (phase_next > PH_CLOSED) ? PH_CLOSED : phase_next;
        end
    end

endmodule

// ----- rtl/if_to_observer_startup_blend_core.sv -----
// channel   direction  handshake          word
// s_        in         s_valid / s_ready  s_kind, s_observer_speed, s_observer_angle
// m_        out        m_valid / m_ready  m_angle_out, m_speed_out, m_current_ref, m_phase_out
// cfg_      in         cfg_we             cfg_index, cfg_wdata
//
// One word in flight: accept, multiply, integrate, the 16-step restoring divider for the blend
// weight, blend multiply, blend sum, commit; the next word is accepted only after the commit.
// Reset (aresetn, synchronous) returns to the open-loop phase with zero synthetic state.
// A result waiting on m_ready does not block the next accept; only a second result stalls.
module if_to_observer_startup_blend_core
    import ifsb_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_W-1:0]            cfg_wdata,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_kind,
    input  logic signed [SPEED_W-1:0]   s_observer_speed,
    input  logic signed [ANGLE_W-1:0]   s_observer_angle,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [ANGLE_W-1:0]   m_angle_out,
    output logic signed [SPEED_W-1:0]   m_speed_out,
    output logic signed [CUR_W-1:0]     m_current_ref,
    output logic [PHASE_W-1:0]          m_phase_out
);

    ifsb_cmd_t  cmd;
    ifsb_stat_t stat;

    ifsb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    ifsb_dp u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_kind           (s_kind),
        .s_observer_speed (s_observer_speed),
        .s_observer_angle (s_observer_angle),
        .m_ready          (m_ready),
        .cmd              (cmd),
        .stat             (stat),
        .m_valid          (m_valid),
        .m_angle_out      (m_angle_out),
        .m_speed_out      (m_speed_out),
        .m_current_ref    (m_current_ref),
        .m_phase_out      (m_phase_out)
    );

endmodule

// ----- rtl/ifsb_checker.sv -----
module ifsb_checker
    import ifsb_pkg::*;
(
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_valid,
    input logic                      s_ready,
    input logic                      m_valid,
    input logic                      m_ready,
    input logic signed [ANGLE_W-1:0] m_angle_out,
    input logic signed [SPEED_W-1:0] m_speed_out,
    input logic signed [CUR_W-1:0]   m_current_ref,
    input logic [PHASE_W-1:0]        m_phase_out
);

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result pending after reset");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second word taken while one is in work");

    a_no_quick_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !$rose(m_valid))
        else $error("result one cycle after accept");

    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_phase_out <= PH_CLOSED)
        else $error("phase code out of range");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_angle_out) && $stable(m_speed_out)
            && $stable(m_current_ref) && $stable(m_phase_out))
        else $error("stalled result changed");

endmodule

bind if_to_observer_startup_blend_core ifsb_checker u_ifsb_checker (.*);

// ----- bench/if_to_observer_startup_blend_core_tb.sv -----
module if_to_observer_startup_blend_core_tb;
    import ifsb_pkg::*;

    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 30;
    localparam int PHASE_WORDS  = 340;
    localparam longint K_FULL   = 65536;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    typedef struct packed {
        logic                      kind;
        logic signed [SPEED_W-1:0] obs_speed;
        logic signed [ANGLE_W-1:0] obs_angle;
    } step_word_t;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] angle;
        logic signed [SPEED_W-1:0] speed;
        logic signed [CUR_W-1:0]   current;
        logic [PHASE_W-1:0]        phase;
    } drive_word_t;

    typedef struct packed {
        logic signed [CUR_W-1:0] cur;
        logic [THR_W-1:0]        start_spd;
        logic [THR_W-1:0]        end_spd;
        logic [PER_W-1:0]        per;
    } setup_t;

    typedef struct packed {
        logic        reconf;
        step_word_t  word;
        logic        typed;
        drive_word_t want;
    } dir_row_t;

    localparam drive_word_t NO_WANT = '0;

    logic                        aclk;
    logic                        aresetn;
    logic                        cfg_we;
    logic [CFG_IDX_W-1:0]        cfg_index;
    logic [CFG_W-1:0]            cfg_wdata;
    logic                        s_valid;
    logic                        s_ready;
    logic                        s_kind;
    logic signed [SPEED_W-1:0]   s_observer_speed;
    logic signed [ANGLE_W-1:0]   s_observer_angle;
    logic                        m_valid;
    logic                        m_ready;
    logic signed [ANGLE_W-1:0]   m_angle_out;
    logic signed [SPEED_W-1:0]   m_speed_out;
    logic signed [CUR_W-1:0]     m_current_ref;
    logic [PHASE_W-1:0]          m_phase_out;

    if_to_observer_startup_blend_core u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_kind           (s_kind),
        .s_observer_speed (s_observer_speed),
        .s_observer_angle (s_observer_angle),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_angle_out      (m_angle_out),
        .m_speed_out      (m_speed_out),
        .m_current_ref    (m_current_ref),
        .m_phase_out      (m_phase_out)
    );

    // sequencer model state
    logic [PHASE_W-1:0] est_phase;
    bit [63:0]          est_angle;
    bit [63:0]          est_speed;
    setup_t             reg_set;

    drive_word_t expected_drive[$];
    int  tx_idle_pct;
    int  rx_stall_pct;
    bit  hold_req;
    int  mismatches;
    int  words_sent;
    int  results_seen;
    int  setups_written;
    int  phase_hits[3];

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("if_to_observer_startup_blend_core_tb: FAIL");
        $finish;
    end

    function automatic longint half_up(input longint v, input int n);
        return (v + (longint'(1) << (n - 1))) >>> n;
    endfunction

    function automatic void advance_angle();
        bit [63:0] inc;
        bit [63:0] sum;
        inc = (est_speed * 64'(reg_set.per) + 64'd8388608) >> 24;
        sum = est_angle + inc;
        if (sum > 64'(TWO_PI_Q24))
            sum = ((sum - 64'd1) % 64'(TWO_PI_Q24)) + 64'd1;
        est_angle = sum;
    endfunction

    function automatic drive_word_t predict_drive(input step_word_t w);
        longint ow, oa, ang, spd, cur, num, den, k, an, ad;
        bit [63:0] lo24, hi24;
        drive_word_t r;
        ow = longint'($signed(w.obs_speed));
        oa = longint'($signed(w.obs_angle));
        lo24 = 64'(reg_set.start_spd) << 16;
        hi24 = 64'(reg_set.end_spd) << 16;
        if (w.kind) begin
            est_phase = PH_OPEN;
            est_angle = 0;
            est_speed = 0;
            ang = 0;
            spd = 0;
            cur = 0;
        end else if (est_phase == PH_OPEN) begin
            advance_angle();
            est_speed += 64'(RAMP_RATE) * 64'(reg_set.per);
            if (est_speed > lo24)
                est_speed = lo24;
            ang = half_up(longint'(est_angle), 12);
            spd = half_up(longint'(est_speed), 16);
            cur = longint'($signed(reg_set.cur));
            if (est_speed >= lo24)
                est_phase = PH_TRANS;
        end else if (est_phase == PH_TRANS) begin
            advance_angle();
            if (est_speed < hi24) begin
                est_speed += 64'(RAMP_RATE) * 64'(reg_set.per);
                if (est_speed > hi24)
                    est_speed = hi24;
            end
            num = ow - longint'(reg_set.start_spd);
            den = longint'(reg_set.end_spd) - longint'(reg_set.start_spd);
            if (den == 0) begin
                k = K_FULL;
            end else if (num == 0 || ((num < 0) != (den < 0))) begin
                k = 0;
            end else begin
                an = (num < 0) ? -num : num;
                ad = (den < 0) ? -den : den;
                k = (an >= ad) ? K_FULL : (an << 16) / ad;
            end
            ang = half_up((K_FULL - k) * longint'(est_angle) + k * (oa * 4096), 28);
            spd = half_up((K_FULL - k) * longint'(est_speed) + k * (ow * 65536), 32);
            cur = longint'($signed(reg_set.cur));
            if (k == K_FULL)
                est_phase = PH_CLOSED;
        end else begin
            ang = oa;
            spd = ow;
            cur = 0;
        end
        if (ang < -32768)
            ang = -32768;
        else if (ang > 32767)
            ang = 32767;
        if (spd < -8388608)
            spd = -8388608;
        else if (spd > 8388607)
            spd = 8388607;
        r.angle   = ang[ANGLE_W-1:0];
        r.speed   = spd[SPEED_W-1:0];
        r.current = cur[CUR_W-1:0];
        r.phase   = (est_phase > PH_CLOSED) ? PH_CLOSED : est_phase;
        return r;
    endfunction

    task automatic send_word(input step_word_t w, input bit typed, input drive_word_t want);
        drive_word_t pred;
        int gap;
        gap = 0;
        while (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct)
            gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_kind           <= w.kind;
        s_observer_speed <= w.obs_speed;
        s_observer_angle <= w.obs_angle;
        do @(posedge aclk); while (!s_ready);
        pred = predict_drive(w);
        expected_drive.push_back(typed ? want : pred);
        words_sent++;
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_drive.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_setup(input setup_t c);
        cfg_we    <= 1'b1;
        cfg_index <= REG_STARTUP_CURRENT;
        cfg_wdata <= {{(CFG_W-CUR_W){c.cur[CUR_W-1]}}, c.cur};
        @(posedge aclk);
        cfg_index <= REG_START_SPEED;
        cfg_wdata <= c.start_spd;
        @(posedge aclk);
        cfg_index <= REG_END_SPEED;
        cfg_wdata <= c.end_spd;
        @(posedge aclk);
        cfg_index <= REG_STEP_PERIOD;
        cfg_wdata <= {{(CFG_W-PER_W){1'b0}}, c.per};
        @(posedge aclk);
        cfg_we <= 1'b0;
        reg_set = c;
        setups_written++;
    endtask

    // result side: ready pattern, long hold-off on request, compare
    initial begin
        drive_word_t e;
        int hold_left;
        hold_left = 0;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                results_seen++;
                if (expected_drive.size() == 0) begin
                    mismatches++;
                    $display("%0t: result with none expected: angle %0d speed %0d cur %0d phase %0d",
                             $time, m_angle_out, m_speed_out, m_current_ref, m_phase_out);
                end else begin
                    e = expected_drive.pop_front();
                    if (e.phase <= PH_CLOSED)
                        phase_hits[e.phase]++;
                    if (m_angle_out !== e.angle) begin
                        mismatches++;
                        $display("%0t: angle_out expected %0d got %0d", $time, e.angle, m_angle_out);
                    end
                    if (m_speed_out !== e.speed) begin
                        mismatches++;
                        $display("%0t: speed_out expected %0d got %0d", $time, e.speed, m_speed_out);
                    end
                    if (m_current_ref !== e.current) begin
                        mismatches++;
                        $display("%0t: current_ref expected %0d got %0d",
                                 $time, e.current, m_current_ref);
                    end
                    if (m_phase_out !== e.phase) begin
                        mismatches++;
                        $display("%0t: phase_out expected %0d got %0d", $time, e.phase, m_phase_out);
                    end
                end
            end
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
            end
        end
    end

    initial begin
        dir_row_t dir_rows[$];
        setup_t dir_setups[$];
        setup_t cs;
        step_word_t w;
        int ci, sent_in_phase, ramp_steps, seq_len, lo, hi, span, v, r, directed;
        longint steps;

        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_kind = 1'b0;
        s_observer_speed = '0;
        s_observer_angle = '0;
        aresetn = 1'b0;
        hold_req = 1'b0;
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        mismatches = 0;
        words_sent = 0;
        results_seen = 0;
        setups_written = 0;
        phase_hits = '{0, 0, 0};
        reg_set = '{16'sd0, 23'd0, 23'd0, STEP_PERIOD_RST};
        est_phase = PH_OPEN;
        est_angle = 0;
        est_speed = 0;
        ci = 0;

        // reset values: equal thresholds at zero, so blend weight is one at once
        dir_rows.push_back('{1'b0, '{1'b0, 24'sd0, 16'sd0}, 1'b1,
                             '{16'sd0, 24'sd0, 16'sd0, PH_TRANS}});
        dir_rows.push_back('{1'b0, '{1'b0, 24'sh800000, 16'sh7fff}, 1'b1,
                             '{16'sh7fff, 24'sh800000, 16'sd0, PH_CLOSED}});
        dir_rows.push_back('{1'b0, '{1'b0, 24'sh7fffff, 16'sh8000}, 1'b1,
                             '{16'sh8000, 24'sh7fffff, 16'sd0, PH_CLOSED}});
        dir_rows.push_back('{1'b0, '{1'b1, 24'sh7fffff, 16'sh7fff}, 1'b1,
                             '{16'sd0, 24'sd0, 16'sd0, PH_OPEN}});
        // ramp to 40, blend to 100
        dir_setups.push_back('{16'sh8000, 23'd40, 23'd100, 16'hffff});
        dir_rows.push_back('{1'b1, '{1'b0, 24'sd0, 16'sd0}, 1'b0, NO_WANT});
        dir_rows.push_back('{1'b0, '{1'b0, 24'sd5, 16'sd100}, 1'b0, NO_WANT});
        dir_rows.push_back('{1'b0, '{1'b0, 24'sd20, 16'sh1234}, 1'b0, NO_WANT});
        dir_rows.push_back('{1'b0, '{1'b0, 24'sd70, 16'sd12345}, 1'b0, NO_WANT});
        dir_rows.push_back('{1'b0, '{1'b0, 24'sd10, -16'sd4000}, 1'b0, NO_WANT});
        dir_rows.push_back('{1'b0, '{1'b0, -24'sd50, 16'sd25000}, 1'b0, NO_WANT});
        dir_rows.push_back('{1'b0, '{1'b0, 24'sd100, 16'sh8000}, 1'b0, NO_WANT});
        dir_rows.push_back('{1'b0, '{1'b1, 24'sh800000, 16'sh8000}, 1'b1,
                             '{16'sd0, 24'sd0, 16'sd0, PH_OPEN}});
        // end threshold below start: ramp holds, weight sign flips
        dir_setups.push_back('{16'sh7fff, 23'd100, 23'd40, 16'hffff});
        dir_rows.push_back('{1'b1, '{1'b0, 24'sd1, 16'sd1}, 1'b0, NO_WANT});
        dir_rows.push_back('{1'b0, '{1'b0, 24'sd2, 16'sd2}, 1'b0, NO_WANT});
        dir_rows.push_back('{1'b0, '{1'b0, 24'sd3, 16'sd3}, 1'b0, NO_WANT});
        dir_rows.push_back('{1'b0, '{1'b0, 24'sd4, 16'sd4}, 1'b0, NO_WANT});
        dir_rows.push_back('{1'b0, '{1'b0, 24'sd5, 16'sd5}, 1'b0, NO_WANT});
        dir_rows.push_back('{1'b0, '{1'b0, 24'sd6, 16'sd6}, 1'b0, NO_WANT});
        dir_rows.push_back('{1'b0, '{1'b0, 24'sd70, 16'sd3000}, 1'b0, NO_WANT});
        dir_rows.push_back('{1'b0, '{1'b0, 24'sd200, -16'sd3000}, 1'b0, NO_WANT});
        dir_rows.push_back('{1'b0, '{1'b0, 24'sd0, 16'sd7777}, 1'b0, NO_WANT});
        // zero step period, unreachable thresholds
        dir_setups.push_back('{-16'sd1, 23'h7fffff, 23'h7fffff, 16'd0});
        dir_rows.push_back('{1'b1, '{1'b1, 24'sd0, 16'sd0}, 1'b1,
                             '{16'sd0, 24'sd0, 16'sd0, PH_OPEN}});
        dir_rows.push_back('{1'b0, '{1'b0, 24'sd9, 16'sd9}, 1'b0, NO_WANT});
        dir_rows.push_back('{1'b0, '{1'b0, -24'sd1, -16'sd1}, 1'b0, NO_WANT});

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].reconf) begin
                settle();
                write_setup(dir_setups[ci]);
                ci++;
            end
            send_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].want);
        end
        directed = words_sent;

        for (int m = 0; m < 4; m++) begin
            settle();
            case (idle_mode_t'(m))
                IDLE_NONE: begin
                    tx_idle_pct = 0;
                    rx_stall_pct = 0;
                end
                IDLE_SENDER: begin
                    tx_idle_pct = 77;
                    rx_stall_pct = 0;
                end
                IDLE_RECEIVER: begin
                    tx_idle_pct = 0;
                    rx_stall_pct = 77;
                end
                default: begin
                    tx_idle_pct = 7;
                    rx_stall_pct = 7;
                end
            endcase
            sent_in_phase = 0;
            while (sent_in_phase < PHASE_WORDS) begin
                settle();
                r = $urandom_range(0, 19);
                cs.cur = (r == 0) ? 16'sh8000 : (r == 1) ? 16'sh7fff : 16'($urandom);
                r = $urandom_range(0, 19);
                if (r < 2)
                    cs.start_spd = 23'd0;
                else if (r < 4)
                    cs.start_spd = 23'h7fffff;
                else if (r < 7)
                    cs.start_spd = 23'($urandom_range(3000, 20000));
                else
                    cs.start_spd = 23'($urandom_range(0, 1500));
                r = $urandom_range(0, 19);
                if (r < 3) begin
                    cs.end_spd = cs.start_spd;
                end else if (r == 3) begin
                    cs.end_spd = 23'h7fffff;
                end else if (r == 4) begin
                    cs.end_spd = 23'd0;
                end else begin
                    v = int'(cs.start_spd) + int'($urandom_range(0, 900)) - 300;
                    if (v < 0)
                        v = 0;
                    if (v > 8388607)
                        v = 8388607;
                    cs.end_spd = v[THR_W-1:0];
                end
                r = $urandom_range(0, 39);
                if (r == 0)
                    cs.per = 16'd0;
                else if (r < 5)
                    cs.per = 16'd1;
                else if (r < 15)
                    cs.per = 16'hffff;
                else
                    cs.per = 16'($urandom_range(8000, 65535));
                write_setup(cs);
                if (m == IDLE_NONE && sent_in_phase == 0)
                    hold_req = 1'b1;

                w.kind = 1'b1;
                w.obs_speed = 24'($urandom);
                w.obs_angle = 16'($urandom);
                send_word(w, 1'b0, NO_WANT);

                if (cs.per == 0) begin
                    ramp_steps = 250;
                end else begin
                    steps = (longint'(cs.start_spd) << 16) / (20 * longint'(cs.per)) + 1;
                    ramp_steps = (steps > 250) ? 250 : int'(steps);
                end
                seq_len = ramp_steps + $urandom_range(5, 60);
                lo = (cs.start_spd < cs.end_spd) ? int'(cs.start_spd) : int'(cs.end_spd);
                hi = (cs.start_spd < cs.end_spd) ? int'(cs.end_spd) : int'(cs.start_spd);
                span = hi - lo + 64;
                for (int n = 0; n < seq_len; n++) begin
                    r = $urandom_range(0, 99);
                    if (r < 5)
                        v = (r < 2) ? -8388608 : 8388607;
                    else if (r < 30)
                        v = int'($signed(24'($urandom)));
                    else
                        v = lo - span + int'($urandom_range(0, 3 * span));
                    if (v < -8388608)
                        v = -8388608;
                    if (v > 8388607)
                        v = 8388607;
                    w.kind = ($urandom_range(0, 99) < 3);
                    w.obs_speed = v[SPEED_W-1:0];
                    w.obs_angle = 16'($urandom);
                    send_word(w, 1'b0, NO_WANT);
                end
                sent_in_phase += seq_len + 1;
            end
        end

        settle();
        $display("%0d words sent (%0d directed), %0d results compared, %0d register setups",
                 words_sent, directed, results_seen, setups_written);
        $display("expected phases: %0d open-loop, %0d transition, %0d closed-loop",
                 phase_hits[0], phase_hits[1], phase_hits[2]);
        if (mismatches == 0) begin
            $display("if_to_observer_startup_blend_core_tb: PASS");
        end else begin
            $display("if_to_observer_startup_blend_core_tb: FAIL");
        end
        $finish;
    end

endmodule
